### rtl/core/assert_macros.svh
// Assertion helpers for the RTL, included by vector2d_normalize.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define V2N_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define V2N_ASSERT_NEVER(label, cond, msg) \
  `V2N_ASSERT(label, !(cond), msg)

`endif

### rtl/core/v2n_pkg.sv
package v2n_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // x^2 + y^2 needs one bit more than a square
  localparam int SQ_W        = 2 * DATA_WIDTH + 1;
  localparam int REM_W       = SQ_W + 1;
  localparam int SQRT_STAGES = DATA_WIDTH;

  // quotient is at most 1.0, so FRAC_BITS + 1 bits
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
  localparam int DREM_W     = NUM_W + 1;
  localparam int DIV_STAGES = Q_W;

  localparam int SQUARE_STAGES = 3;
  localparam int LATENCY       = SQUARE_STAGES + SQRT_STAGES + DIV_STAGES + 1;

  localparam logic [DATA_WIDTH-1:0] MIN_MAG_RESET = DATA_WIDTH'(7);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_out;
    logic signed [DATA_WIDTH-1:0] y_out;
    logic [DATA_WIDTH-1:0]        magnitude;
    logic                         was_normalized;
  } result_t;

  // request plus absolute components, carried down the pipe
  typedef struct packed {
    req_t                  req;
    logic [DATA_WIDTH-1:0] ax;
    logic [DATA_WIDTH-1:0] ay;
  } side_t;

endpackage

### rtl/core/v2n_square.sv
module v2n_square (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  v2n_pkg::req_t       req_i,
  output logic                valid_o,
  output v2n_pkg::side_t      side_o,
  output logic [v2n_pkg::SQ_W-1:0] radicand_o
);
  import v2n_pkg::*;

  logic                    v1_q, v2_q, v3_q;
  side_t                   s1_d, s1_q, s2_q, s3_q;
  logic [2*DATA_WIDTH-1:0] sqx_q, sqy_q;
  logic [SQ_W-1:0]         sum_q;

  // stage 1: absolute values, exact for the most negative code
  always_comb begin
    s1_d.req = req_i;
    s1_d.ax  = req_i.x_in[DATA_WIDTH-1] ? (~req_i.x_in + 1'b1) : req_i.x_in;
    s1_d.ay  = req_i.y_in[DATA_WIDTH-1] ? (~req_i.y_in + 1'b1) : req_i.y_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    // stage 2: squares
    s2_q  <= s1_q;
    sqx_q <= s1_q.ax * s1_q.ax;
    sqy_q <= s1_q.ay * s1_q.ay;
    // stage 3: sum
    s3_q  <= s2_q;
    sum_q <= SQ_W'(sqx_q) + SQ_W'(sqy_q);
  end

  assign valid_o    = v3_q;
  assign side_o     = s3_q;
  assign radicand_o = sum_q;

endmodule

### rtl/core/v2n_sqrt.sv
module v2n_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  v2n_pkg::side_t                side_i,
  input  logic [v2n_pkg::SQ_W-1:0]      radicand_i,
  output logic                          valid_o,
  output v2n_pkg::side_t                side_o,
  output logic [v2n_pkg::DATA_WIDTH-1:0] root_o
);
  import v2n_pkg::*;

  // index 0 is the input, index s+1 the register of stage s
  logic                  valid_q [SQRT_STAGES+1];
  side_t                 side_q  [SQRT_STAGES+1];
  logic [REM_W-1:0]      rem_q   [SQRT_STAGES+1];
  logic [DATA_WIDTH-1:0] root_q  [SQRT_STAGES+1];

  assign valid_q[0] = valid_i;
  assign side_q[0]  = side_i;
  assign rem_q[0]   = REM_W'(radicand_i);
  assign root_q[0]  = '0;

  // one root bit per stage, from the top
  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - s;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = (REM_W'(root_q[s]) << (B + 1)) | (REM_W'(1) << (2 * B));
      take  = rem_q[s] >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s+1] <= side_q[s];
      rem_q[s+1]  <= take ? (rem_q[s] - trial) : rem_q[s];
      root_q[s+1] <= take ? (root_q[s] | (DATA_WIDTH'(1) << B)) : root_q[s];
    end
  end

  assign valid_o = valid_q[SQRT_STAGES];
  assign side_o  = side_q[SQRT_STAGES];
  assign root_o  = root_q[SQRT_STAGES];

endmodule

### rtl/core/v2n_div.sv
module v2n_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  v2n_pkg::side_t                 side_i,
  input  logic [v2n_pkg::DATA_WIDTH-1:0] mag_i,
  output logic                           valid_o,
  output v2n_pkg::side_t                 side_o,
  output logic [v2n_pkg::DATA_WIDTH-1:0] mag_o,
  output logic [v2n_pkg::Q_W-1:0]        qx_o,
  output logic [v2n_pkg::Q_W-1:0]        qy_o
);
  import v2n_pkg::*;

  logic                  valid_q [DIV_STAGES+1];
  side_t                 side_q  [DIV_STAGES+1];
  logic [DATA_WIDTH-1:0] mag_q   [DIV_STAGES+1];
  logic [DREM_W-1:0]     rx_q    [DIV_STAGES+1];
  logic [DREM_W-1:0]     ry_q    [DIV_STAGES+1];
  logic [Q_W-1:0]        qx_q    [DIV_STAGES+1];
  logic [Q_W-1:0]        qy_q    [DIV_STAGES+1];

  // numerators are |component| << FRAC_BITS
  assign valid_q[0] = valid_i;
  assign side_q[0]  = side_i;
  assign mag_q[0]   = mag_i;
  assign rx_q[0]    = DREM_W'({side_i.ax, {FRAC_BITS{1'b0}}});
  assign ry_q[0]    = DREM_W'({side_i.ay, {FRAC_BITS{1'b0}}});
  assign qx_q[0]    = '0;
  assign qy_q[0]    = '0;

  // restoring division, both lanes share the divisor
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int I = DIV_STAGES - 1 - s;
    logic [DREM_W-1:0] dsh;
    logic              tx, ty;

    always_comb begin
      dsh = DREM_W'(mag_q[s]) << I;
      tx  = rx_q[s] >= dsh;
      ty  = ry_q[s] >= dsh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s+1] <= side_q[s];
      mag_q[s+1]  <= mag_q[s];
      rx_q[s+1]   <= tx ? (rx_q[s] - dsh) : rx_q[s];
      ry_q[s+1]   <= ty ? (ry_q[s] - dsh) : ry_q[s];
      qx_q[s+1]   <= qx_q[s] | (tx ? (Q_W'(1) << I) : '0);
      qy_q[s+1]   <= qy_q[s] | (ty ? (Q_W'(1) << I) : '0);
    end
  end

  assign valid_o = valid_q[DIV_STAGES];
  assign side_o  = side_q[DIV_STAGES];
  assign mag_o   = mag_q[DIV_STAGES];
  assign qx_o    = qx_q[DIV_STAGES];
  assign qy_o    = qy_q[DIV_STAGES];

endmodule

### rtl/core/vector2d_normalize.sv
// Pipeline from an accepted request to its done_o strobe: 3 square/sum stages,
// 32 square-root stages, 17 divider stages and 1 output register.
// Throughput: one request per cycle; busy_o is always low, results cannot be held off.
// Reset: rst_ni (async, active low) drops all requests in flight and sets
// min_magnitude to 7 (about 0.0001 in Q16.16).
module vector2d_normalize (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           start_i,
  output logic                           busy_o,
  input  v2n_pkg::req_t                  req_i,
  // result strobe
  output logic                           done_o,
  output v2n_pkg::result_t               res_o,
  // min_magnitude register
  input  logic                           cfg_we_i,
  input  logic [v2n_pkg::DATA_WIDTH-1:0] cfg_wdata_i
);
  import v2n_pkg::*;
  `include "assert_macros.svh"

  localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

  logic [DATA_WIDTH-1:0] min_mag_q;

  logic                  sq_valid;
  side_t                 sq_side;
  logic [SQ_W-1:0]       sq_rad;

  logic                  rt_valid;
  side_t                 rt_side;
  logic [DATA_WIDTH-1:0] rt_root;

  logic                  dv_valid;
  side_t                 dv_side;
  logic [DATA_WIDTH-1:0] dv_mag;
  logic [Q_W-1:0]        dv_qx, dv_qy;

  logic                  done_q;
  result_t               res_d, res_q;

  logic                  out_norm;
  logic                  out_unit;

  // Fully pipelined: never refuses a request.
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= MIN_MAG_RESET;
    end else if (cfg_we_i) begin
      min_mag_q <= cfg_wdata_i;
    end
  end

  // |x|, |y| and x^2 + y^2 at full precision
  v2n_square u_square (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i && !busy_o),
    .req_i      (req_i),
    .valid_o    (sq_valid),
    .side_o     (sq_side),
    .radicand_o (sq_rad)
  );

  // Truncated magnitude, Q16.16 falls out of the Q32.32 radicand
  v2n_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (sq_valid),
    .side_i     (sq_side),
    .radicand_i (sq_rad),
    .valid_o    (rt_valid),
    .side_o     (rt_side),
    .root_o     (rt_root)
  );

  // |component| / magnitude for both lanes. Always runs; the result is
  // simply discarded on pass-through (including magnitude zero).
  v2n_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rt_valid),
    .side_i  (rt_side),
    .mag_i   (rt_root),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .mag_o   (dv_mag),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy)
  );

  // Threshold check and sign restore. Config must only move while idle (the block
  // does not enforce it), so that the live register is the one the request saw.
  always_comb begin
    res_d.magnitude      = dv_mag;
    res_d.was_normalized = dv_mag > min_mag_q;
    if (res_d.was_normalized) begin
      res_d.x_out = dv_side.req.x_in[DATA_WIDTH-1] ? -DATA_WIDTH'(dv_qx) : DATA_WIDTH'(dv_qx);
      res_d.y_out = dv_side.req.y_in[DATA_WIDTH-1] ? -DATA_WIDTH'(dv_qy) : DATA_WIDTH'(dv_qy);
    end else begin
      res_d.x_out = dv_side.req.x_in;
      res_d.y_out = dv_side.req.y_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  assign out_norm = done_o && res_o.was_normalized;
  assign out_unit = res_o.x_out <= ONE && res_o.x_out >= -ONE &&
                    res_o.y_out <= ONE && res_o.y_out >= -ONE;

  // Normalizing needs a nonzero magnitude.
  `V2N_ASSERT_NEVER(a_norm_zero_mag, out_norm && res_o.magnitude == '0, "normalized, zero magnitude")
  // A unit vector component stays within +/- 1.0.
  `V2N_ASSERT(a_norm_range, out_norm |-> out_unit, "normalized component out of range")
  // A normalized vector cannot collapse to zero.
  `V2N_ASSERT_NEVER(a_norm_nonzero, out_norm && {res_o.x_out, res_o.y_out} == '0, "zero unit vector")

endmodule

### sim/v2n_checker.sv
`timescale 1ns / 1ps

// Scoreboard for vector2d_normalize: predicts each accepted request and
// compares every done_o strobe against the oldest prediction.
module v2n_checker
  import v2n_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  req_t                  req_i,
  input  logic                  done_i,
  input  result_t               res_i,
  input  logic                  cfg_we_i,
  input  logic [DATA_WIDTH-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o
);

  logic [DATA_WIDTH-1:0] min_mag_q;
  result_t               unit_vec_q[$];

  function automatic result_t unit_vector(req_t r, logic [DATA_WIDTH-1:0] thr);
    logic [DATA_WIDTH-1:0]           ax, ay, mag, cand;
    logic [2*DATA_WIDTH:0]           sumsq;
    logic [DATA_WIDTH+FRAC_BITS-1:0] qx, qy;
    result_t                         o;
    ax = r.x_in[DATA_WIDTH-1] ? ~r.x_in + 1'b1 : r.x_in;
    ay = r.y_in[DATA_WIDTH-1] ? ~r.y_in + 1'b1 : r.y_in;
    sumsq = (2*DATA_WIDTH+1)'(ax) * (2*DATA_WIDTH+1)'(ax)
          + (2*DATA_WIDTH+1)'(ay) * (2*DATA_WIDTH+1)'(ay);
    mag = '0;
    for (int b = DATA_WIDTH - 1; b >= 0; b--) begin
      cand = mag | (DATA_WIDTH'(1) << b);
      if ((2*DATA_WIDTH+1)'(cand) * (2*DATA_WIDTH+1)'(cand) <= sumsq) mag = cand;
    end
    o.magnitude = mag;
    if (mag > thr) begin
      qx = {ax, {FRAC_BITS{1'b0}}} / (DATA_WIDTH+FRAC_BITS)'(mag);
      qy = {ay, {FRAC_BITS{1'b0}}} / (DATA_WIDTH+FRAC_BITS)'(mag);
      o.x_out = r.x_in[DATA_WIDTH-1] ? -qx[DATA_WIDTH-1:0] : qx[DATA_WIDTH-1:0];
      o.y_out = r.y_in[DATA_WIDTH-1] ? -qy[DATA_WIDTH-1:0] : qy[DATA_WIDTH-1:0];
      o.was_normalized = 1'b1;
    end else begin
      o.x_out = r.x_in;
      o.y_out = r.y_in;
      o.was_normalized = 1'b0;
    end
    return o;
  endfunction

  assign pending_o = unit_vec_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    if (!rst_ni) begin
      min_mag_q = MIN_MAG_RESET;
      unit_vec_q.delete();
      errors_o = 0;
    end else begin
      if (start_i && !busy_i) unit_vec_q.push_back(unit_vector(req_i, min_mag_q));
      if (cfg_we_i) min_mag_q = cfg_wdata_i;
      if (done_i) begin
        if (unit_vec_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res_i);
          errors_o++;
        end else begin
          exp_res = unit_vec_q.pop_front();
          if (res_i.x_out !== exp_res.x_out || res_i.y_out !== exp_res.y_out ||
              res_i.magnitude !== exp_res.magnitude ||
              res_i.was_normalized !== exp_res.was_normalized) begin
            $display("%0t: mismatch exp x=%h y=%h mag=%h n=%b act x=%h y=%h mag=%h n=%b",
                     $time, exp_res.x_out, exp_res.y_out, exp_res.magnitude,
                     exp_res.was_normalized, res_i.x_out, res_i.y_out,
                     res_i.magnitude, res_i.was_normalized);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict; all prediction lives in v2n_checker.
module tb_top;
  import v2n_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles with no request or result accepted

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  req_t                  req_i = '0;
  logic                  done_o;
  result_t               res_o;
  logic                  cfg_we_i = 1'b0;
  logic [DATA_WIDTH-1:0] cfg_wdata_i = '0;
  int                    errors;
  int                    pending;
  int                    idle_cycles = 0;
  bit                    no_gaps;    // phase runs back to back when set

  vector2d_normalize dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o, .cfg_we_i, .cfg_wdata_i
  );

  v2n_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_i, .done_i(done_o), .res_i(res_o),
    .cfg_we_i, .cfg_wdata_i, .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: no request and no result for too long means the block hung
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge once the request
  // is taken. busy_o only moves on rising edges, so sampling it here tells
  // whether the coming edge accepts.
  task automatic send_vec(logic [DATA_WIDTH-1:0] x, logic [DATA_WIDTH-1:0] y);
    bit taken;
    int gap;
    start_i = 1'b1;
    req_i.x_in = x;
    req_i.y_in = y;
    do begin
      taken = !busy_o;
      @(negedge clk_i);
    end while (!taken);
    // mostly no gap, sometimes a short one, now and then a long one
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4:  gap = $urandom_range(1, 3);
        5:              gap = $urandom_range(10, 60);
        default:        gap = 0;
      endcase
    end
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // threshold writes only once the pipe has drained
  task automatic set_threshold(logic [DATA_WIDTH-1:0] thr);
    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = thr;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random vector: full range, small lengths, or near the threshold
  task automatic send_random(logic [DATA_WIDTH-1:0] thr);
    logic [DATA_WIDTH-1:0] x, y;
    case ($urandom_range(3))
      0: begin
        x = $urandom;
        y = $urandom;
      end
      1: begin
        x = $urandom_range(0, 4 << FRAC_BITS) - (2 << FRAC_BITS);
        y = $urandom_range(0, 4 << FRAC_BITS) - (2 << FRAC_BITS);
      end
      2: begin
        x = $urandom_range(0, 40) - 20;
        y = $urandom_range(0, 40) - 20;
      end
      default: begin
        // length close to the threshold along one axis, random if the threshold is too large
        x = (thr > 32'h7fff_0000) ? $urandom : thr + $urandom_range(0, 2) - 1;
        y = $urandom_range(0, 2) - 1;
        if ($urandom_range(1)) x = -x;
      end
    endcase
    send_vec(x, y);
  endtask

  initial begin
    logic [DATA_WIDTH-1:0] thr_list[5];
    thr_list = '{32'd0, 32'hffff_ffff, 32'd65536, 32'd7, 32'd0};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset threshold first
    no_gaps = 1'b0;
    send_vec(32'd0, 32'd0);                    // zero vector passes through
    send_vec(32'h8000_0000, 32'h8000_0000);    // most negative on both axes
    send_vec(32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h8000_0000, 32'd0);
    send_vec(32'd0, 32'h7fff_ffff);
    send_vec(32'd7, 32'd0);                    // length equal to threshold
    send_vec(32'd8, 32'd0);                    // just above threshold
    send_vec(-32'd8, 32'd0);
    send_vec(32'd3 << FRAC_BITS, -(32'd4 << FRAC_BITS));
    send_vec(32'd1, 32'hffff_ffff);

    set_threshold(32'd65536);
    send_vec(32'd65536, 32'd0);                // exactly at threshold: no divide
    send_vec(32'd65537, 32'd0);
    send_vec(32'd0, -32'd65537);
    set_threshold(32'hffff_ffff);              // nothing ever normalizes
    send_vec(32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h8000_0000);
    set_threshold(32'd0);                      // anything nonzero normalizes
    send_vec(32'd1, 32'd0);
    send_vec(32'd0, 32'd0);
    send_vec(32'h8000_0000, 32'h7fff_ffff);

    // random phases over several thresholds
    for (int ph = 0; ph < 6; ph++) begin
      logic [DATA_WIDTH-1:0] thr;
      thr = (ph < 5) ? thr_list[ph] : $urandom_range(0, 1 << (FRAC_BITS + 2));
      set_threshold(thr);
      no_gaps = (ph % 3 == 1);
      repeat (265) send_random(thr);
    end

    start_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
